// ===== src/sdo_round_robin_read_poller_unit_defines.svh =====
// Assertion macros shared by the poller RTL
`ifndef SDO_ROUND_ROBIN_READ_POLLER_UNIT_DEFINES_SVH
`define SDO_ROUND_ROBIN_READ_POLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define SDO_RRP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdo_rrp: check failed");

// Next-cycle implication
`define SDO_RRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdo_rrp: check failed");

`endif

// ===== src/sdo_rrp_pkg.sv =====
package sdo_rrp_pkg;

    // Rotation slots
    localparam int TARGET_COUNT_DEF = 3;
    localparam int SLOT_W           = 2;
    localparam logic [SLOT_W-1:0] SLOT_ZERO = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_ONE  = 2'd1;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STATE_FRAME_ID    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_FRAME_ID = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PERIOD     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_PERIOD       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_TIME        = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FIRST      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SECOND     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_THIRD      = 4'd7;

    // Register reset values
    localparam logic [10:0] RST_STATE_FRAME_ID    = 11'd2;
    localparam logic [10:0] RST_RESPONSE_FRAME_ID = 11'd1409;
    localparam logic [31:0] RST_ACTIVE_PERIOD     = 32'd100000;
    localparam logic [31:0] RST_IDLE_PERIOD       = 32'd1000000;
    localparam logic [31:0] RST_STALE_TIME        = 32'd500000;
    localparam logic [15:0] RST_TARGET_FIRST      = 16'd2015;
    localparam logic [15:0] RST_TARGET_SECOND     = 16'd2016;
    localparam logic [15:0] RST_TARGET_THIRD      = 16'd2051;

    // SDO protocol codes
    localparam logic [7:0]  SDO_CMD_READ  = 8'h40;
    localparam logic [7:0]  SDO_CMD_ABORT = 8'h80;
    localparam logic [15:0] SDO_UID_INDEX = 16'h2100;

    // Item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // Minimum lengths
    localparam logic [3:0] LEN_STATE_MIN    = 4'd3;
    localparam logic [3:0] LEN_RESPONSE_MIN = 4'd8;

    typedef struct packed {
        logic [10:0] state_frame_id;
        logic [10:0] response_frame_id;
        logic [31:0] active_period_us;
        logic [31:0] idle_period_us;
        logic [31:0] stale_time_us;
        logic [15:0] target_id_first;
        logic [15:0] target_id_second;
        logic [15:0] target_id_third;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] now_us;
        logic        frame_standard;
        logic [10:0] frame_id;
        logic [3:0]  frame_length;
        logic [63:0] frame_payload;
        logic        transmit_accepted;
    } item_t;

    typedef struct packed {
        logic        request_valid;
        logic [63:0] request_payload;
        logic        abort_valid;
        logic [15:0] abort_param_id;
        logic [31:0] abort_code;
    } result_t;

    typedef struct packed {
        logic pending;
        logic all_retired;
    } status_t;

endpackage

// ===== src/sdo_rrp_cfg.sv =====
module sdo_rrp_cfg
    import sdo_rrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Register file, one write per transfer; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.state_frame_id    <= RST_STATE_FRAME_ID;
            cfg_reg.response_frame_id <= RST_RESPONSE_FRAME_ID;
            cfg_reg.active_period_us  <= RST_ACTIVE_PERIOD;
            cfg_reg.idle_period_us    <= RST_IDLE_PERIOD;
            cfg_reg.stale_time_us     <= RST_STALE_TIME;
            cfg_reg.target_id_first   <= RST_TARGET_FIRST;
            cfg_reg.target_id_second  <= RST_TARGET_SECOND;
            cfg_reg.target_id_third   <= RST_TARGET_THIRD;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_STATE_FRAME_ID:    cfg_reg.state_frame_id    <= wr_data[10:0];
                REG_RESPONSE_FRAME_ID: cfg_reg.response_frame_id <= wr_data[10:0];
                REG_ACTIVE_PERIOD:     cfg_reg.active_period_us  <= wr_data;
                REG_IDLE_PERIOD:       cfg_reg.idle_period_us    <= wr_data;
                REG_STALE_TIME:        cfg_reg.stale_time_us     <= wr_data;
                REG_TARGET_FIRST:      cfg_reg.target_id_first   <= wr_data[15:0];
                REG_TARGET_SECOND:     cfg_reg.target_id_second  <= wr_data[15:0];
                REG_TARGET_THIRD:      cfg_reg.target_id_third   <= wr_data[15:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/sdo_rrp_core.sv =====
module sdo_rrp_core
    import sdo_rrp_pkg::*;
#(
    parameter int TARGET_COUNT = TARGET_COUNT_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result,
    output status_t status
);

    localparam int SUM_W = SLOT_W + 1;

    // Poller state
    logic [7:0]              mode_reg,          mode_next;
    logic [31:0]             state_time_reg,    state_time_next;
    logic [31:0]             poll_time_reg,     poll_time_next;
    logic [SLOT_W-1:0]       next_slot_reg,     next_slot_next;
    logic                    pending_reg,       pending_next;
    logic [SLOT_W-1:0]       pending_slot_reg,  pending_slot_next;
    logic [15:0]             pending_index_reg, pending_index_next;
    logic [7:0]              pending_sub_reg,   pending_sub_next;
    logic [TARGET_COUNT-1:0] retired_reg,       retired_next;

    // Step temporaries
    logic [31:0]       state_age;
    logic [31:0]       poll_age;
    logic [31:0]       interval;
    logic [7:0]        mode_eff;
    logic              elapsed;
    logic [SUM_W-1:0]  sum;
    logic [SLOT_W-1:0] cand;
    logic              cand_retired;
    logic              found;
    logic [SLOT_W-1:0] pick;
    logic [SUM_W-1:0]  pick_inc;
    logic [15:0]       pick_id;
    logic [15:0]       req_index;
    logic [7:0]        req_sub;
    logic [15:0]       rsp_index;
    logic              rsp_match;

    function automatic logic [15:0] slot_id(input logic [SLOT_W-1:0] slot, input cfg_t c);
        logic [15:0] id;
        case (slot)
            SLOT_ZERO: id = c.target_id_first;
            SLOT_ONE:  id = c.target_id_second;
            default:   id = c.target_id_third;
        endcase
        return id;
    endfunction

    // Wrap-safe ages and the active poll interval
    assign state_age = item.now_us - state_time_reg;
    assign poll_age  = item.now_us - poll_time_reg;
    assign mode_eff  = (state_age > cfg.stale_time_us) ? 8'd0 : mode_reg;
    assign interval  = (mode_eff != 8'd0) ? cfg.active_period_us : cfg.idle_period_us;
    assign elapsed   = (poll_age >= interval);

    // Round-robin search for the first target not retired
    always_comb
    begin
        found        = 1'b0;
        pick         = next_slot_reg;
        sum          = '0;
        cand         = '0;
        cand_retired = 1'b0;
        for (int i = 0; i < TARGET_COUNT; i++)
        begin
            sum  = {1'b0, next_slot_reg} + SUM_W'(i);
            cand = (sum >= SUM_W'(TARGET_COUNT)) ? SLOT_W'(sum - SUM_W'(TARGET_COUNT))
                                                 : sum[SLOT_W-1:0];
            cand_retired = 1'b0;
            for (int k = 0; k < TARGET_COUNT; k++)
            begin
                if (cand == SLOT_W'(k))
                begin
                    cand_retired = retired_reg[k];
                end
            end
            if (!found && !cand_retired)
            begin
                found = 1'b1;
                pick  = cand;
            end
        end
    end

    assign pick_inc  = {1'b0, pick} + SUM_W'(1);
    assign pick_id   = slot_id(pick, cfg);
    assign req_index = SDO_UID_INDEX | {8'd0, pick_id[15:8]};
    assign req_sub   = pick_id[7:0];

    // Response matching against the outstanding request
    assign rsp_index = item.frame_payload[23:8];
    assign rsp_match = (rsp_index == pending_index_reg)
                    && (item.frame_payload[31:24] == pending_sub_reg);

    // One item's state update and result
    always_comb
    begin
        mode_next          = mode_reg;
        state_time_next    = state_time_reg;
        poll_time_next     = poll_time_reg;
        next_slot_next     = next_slot_reg;
        pending_next       = pending_reg;
        pending_slot_next  = pending_slot_reg;
        pending_index_next = pending_index_reg;
        pending_sub_next   = pending_sub_reg;
        retired_next       = retired_reg;
        result             = '0;

        if (item.kind == KIND_TICK)
        begin
            mode_next = mode_eff;
            if (elapsed)
            begin
                poll_time_next = item.now_us;
                pending_next   = 1'b0;
                if (found)
                begin
                    next_slot_next = (pick_inc == SUM_W'(TARGET_COUNT)) ? SLOT_ZERO
                                                                        : pick_inc[SLOT_W-1:0];
                    result.request_valid   = 1'b1;
                    result.request_payload = {32'd0, req_sub, req_index, SDO_CMD_READ};
                    if (item.transmit_accepted)
                    begin
                        pending_next       = 1'b1;
                        pending_slot_next  = pick;
                        pending_index_next = req_index;
                        pending_sub_next   = req_sub;
                    end
                end
            end
        end
        else if (item.frame_standard)
        begin
            if (item.frame_id == cfg.state_frame_id)
            begin
                if (item.frame_length >= LEN_STATE_MIN)
                begin
                    mode_next       = item.frame_payload[23:16];
                    state_time_next = item.now_us;
                end
            end
            else if (item.frame_id == cfg.response_frame_id
                     && item.frame_length >= LEN_RESPONSE_MIN && pending_reg)
            begin
                if (rsp_match)
                begin
                    if (item.frame_payload[7:0] == SDO_CMD_ABORT)
                    begin
                        for (int k = 0; k < TARGET_COUNT; k++)
                        begin
                            if (pending_slot_reg == SLOT_W'(k))
                            begin
                                retired_next[k] = 1'b1;
                            end
                        end
                        result.abort_valid    = 1'b1;
                        result.abort_param_id = slot_id(pending_slot_reg, cfg);
                        result.abort_code     = item.frame_payload[63:32];
                    end
                    pending_next = 1'b0;
                end
            end
        end
    end

    // State registers advance once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= '0;
            state_time_reg    <= '0;
            poll_time_reg     <= '0;
            next_slot_reg     <= '0;
            pending_reg       <= 1'b0;
            pending_slot_reg  <= '0;
            pending_index_reg <= '0;
            pending_sub_reg   <= '0;
            retired_reg       <= '0;
        end
        else if (step)
        begin
            mode_reg          <= mode_next;
            state_time_reg    <= state_time_next;
            poll_time_reg     <= poll_time_next;
            next_slot_reg     <= next_slot_next;
            pending_reg       <= pending_next;
            pending_slot_reg  <= pending_slot_next;
            pending_index_reg <= pending_index_next;
            pending_sub_reg   <= pending_sub_next;
            retired_reg       <= retired_next;
        end
    end

    assign status.pending     = pending_reg;
    assign status.all_retired = &retired_reg;

endmodule

// ===== src/sdo_round_robin_read_poller_unit.sv =====
// An input item goes into the input register, then its result into the result register;
// the result transfer waits there until out_ready is high.
// Throughput: one item per cycle unless out_ready stalls; the input register feeds one step
// of logic that updates the poller state and loads the result register in the same cycle.
// Reset (rst_n low, asynchronous) clears the state, empties both pipeline registers
// and loads the configuration registers with their default values.
`include "sdo_round_robin_read_poller_unit_defines.svh"

module sdo_round_robin_read_poller_unit
    import sdo_rrp_pkg::*;
#(
    parameter int TARGET_COUNT = TARGET_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [31:0]           now_us,
    input  logic                  frame_standard,
    input  logic [10:0]           frame_id,
    input  logic [3:0]            frame_length,
    input  logic [63:0]           frame_payload,
    input  logic                  transmit_accepted,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  request_valid,
    output logic [63:0]           request_payload,
    output logic                  abort_valid,
    output logic [15:0]           abort_param_id,
    output logic [31:0]           abort_code,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t result_reg;
    logic    fire;
    cfg_t    cfg;
    result_t step_result;
    status_t status;

    // Step happens when an item waits and the result slot is free or draining
    assign fire      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    // Configuration registers
    sdo_rrp_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.kind              <= kind;
            item_reg.now_us            <= now_us;
            item_reg.frame_standard    <= frame_standard;
            item_reg.frame_id          <= frame_id;
            item_reg.frame_length      <= frame_length;
            item_reg.frame_payload     <= frame_payload;
            item_reg.transmit_accepted <= transmit_accepted;
        end
    end

    // Poller state and step logic
    sdo_rrp_core #(
        .TARGET_COUNT (TARGET_COUNT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (step_result),
        .status (status)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign request_valid   = result_reg.request_valid;
    assign request_payload = result_reg.request_payload;
    assign abort_valid     = result_reg.abort_valid;
    assign abort_param_id  = result_reg.abort_param_id;
    assign abort_code      = result_reg.abort_code;

    // A result is either a request or an abort report, never both
    `SDO_RRP_ASSERT_IMPL(a_one_kind, out_valid_reg, !(result_reg.request_valid && result_reg.abort_valid))
    // No request is offered once every target is retired
    `SDO_RRP_ASSERT_IMPL(a_no_req_all_retired, fire && step_result.request_valid, !status.all_retired)
    // An abort can only close an outstanding request
    `SDO_RRP_ASSERT_IMPL(a_abort_needs_pending, fire && step_result.abort_valid, status.pending)
    // A waiting item is kept while the result side is stalled
    `SDO_RRP_ASSERT_NEXT(a_hold_stalled, in_valid_reg && out_valid_reg && !out_ready, in_valid_reg)

endmodule

// ===== bench/sdo_round_robin_read_poller_unit_test.sv =====
`timescale 1ns / 100ps

import sdo_rrp_pkg::*;

// Tracks poller state and config, queues the reply each input transfer should produce
class poll_tracker;
    // register copies
    logic [10:0] state_id;
    logic [10:0] resp_id;
    logic [31:0] active_period;
    logic [31:0] idle_period;
    logic [31:0] stale_time;
    logic [15:0] target_ids [3];

    // poller state
    logic [7:0]  mode;
    logic [31:0] mode_stamp;
    logic [31:0] poll_stamp;
    logic [1:0]  rotor;
    logic        busy;
    logic [1:0]  busy_slot;
    logic [15:0] busy_index;
    logic [7:0]  busy_sub;
    logic [2:0]  retired;

    result_t     replies_due [$];
    int unsigned failures;

    function new();
        state_id      = RST_STATE_FRAME_ID;
        resp_id       = RST_RESPONSE_FRAME_ID;
        active_period = RST_ACTIVE_PERIOD;
        idle_period   = RST_IDLE_PERIOD;
        stale_time    = RST_STALE_TIME;
        target_ids[0] = RST_TARGET_FIRST;
        target_ids[1] = RST_TARGET_SECOND;
        target_ids[2] = RST_TARGET_THIRD;
        mode          = '0;
        mode_stamp    = '0;
        poll_stamp    = '0;
        rotor         = '0;
        busy          = 1'b0;
        busy_slot     = '0;
        busy_index    = '0;
        busy_sub      = '0;
        retired       = '0;
        failures      = 0;
    endfunction

    function logic [31:0] poll_interval();
        return (mode != 8'd0) ? active_period : idle_period;
    endfunction

    // Register write; indexes past the list are dropped
    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_STATE_FRAME_ID:    state_id = data[10:0];
            REG_RESPONSE_FRAME_ID: resp_id = data[10:0];
            REG_ACTIVE_PERIOD:     active_period = data;
            REG_IDLE_PERIOD:       idle_period = data;
            REG_STALE_TIME:        stale_time = data;
            REG_TARGET_FIRST:      target_ids[0] = data[15:0];
            REG_TARGET_SECOND:     target_ids[1] = data[15:0];
            REG_TARGET_THIRD:      target_ids[2] = data[15:0];
            default: ;
        endcase
    endfunction

    // Step the poller for one accepted item and queue its reply
    function void note_transfer(item_t it);
        result_t     r;
        logic [31:0] age;
        logic [31:0] interval;
        logic [1:0]  cand;
        logic [15:0] uid;
        logic [15:0] idx;
        logic [7:0]  sub;
        logic        found;
        int          k;
        r = '0;
        if (it.kind == KIND_TICK) begin
            age = it.now_us - mode_stamp;
            if (age > stale_time)
                mode = '0;
            interval = poll_interval();
            age = it.now_us - poll_stamp;
            if (age >= interval) begin
                poll_stamp = it.now_us;
                busy = 1'b0;
                found = 1'b0;
                // next non-retired slot, round robin
                for (k = 0; k < 3; k++) begin
                    cand = 2'((rotor + k) % 3);
                    if (!found && !retired[cand]) begin
                        found = 1'b1;
                        uid = target_ids[cand];
                        idx = SDO_UID_INDEX | (uid >> 8);
                        sub = uid[7:0];
                        rotor = 2'((cand + 1) % 3);
                        r.request_valid = 1'b1;
                        r.request_payload = {32'h0, sub, idx[15:8], idx[7:0], SDO_CMD_READ};
                        if (it.transmit_accepted) begin
                            busy = 1'b1;
                            busy_slot = cand;
                            busy_index = idx;
                            busy_sub = sub;
                        end
                    end
                end
            end
        end else if (it.frame_standard) begin
            if (it.frame_id == state_id) begin
                if (it.frame_length >= LEN_STATE_MIN) begin
                    mode = it.frame_payload[23:16];
                    mode_stamp = it.now_us;
                end
            end else if (it.frame_id == resp_id && it.frame_length >= LEN_RESPONSE_MIN
                         && busy) begin
                idx = it.frame_payload[23:8];
                if (idx == busy_index && it.frame_payload[31:24] == busy_sub) begin
                    if (it.frame_payload[7:0] == SDO_CMD_ABORT) begin
                        retired[busy_slot] = 1'b1;
                        r.abort_valid = 1'b1;
                        r.abort_param_id = target_ids[busy_slot];
                        r.abort_code = it.frame_payload[63:32];
                    end
                    busy = 1'b0;
                end
            end
        end
        replies_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t %s: expected %h, got %h", $time, name, want, got);
            failures++;
        end
    endfunction

    // Compare one reply transfer with the oldest queued reply
    function void check_reply(result_t got);
        result_t want;
        if (replies_due.size() == 0) begin
            $display("%0t reply: expected none, got %h", $time, got);
            failures++;
            return;
        end
        want = replies_due.pop_front();
        compare_field("request_valid", 64'(want.request_valid), 64'(got.request_valid));
        compare_field("request_payload", want.request_payload, got.request_payload);
        compare_field("abort_valid", 64'(want.abort_valid), 64'(got.abort_valid));
        compare_field("abort_param_id", 64'(want.abort_param_id), 64'(got.abort_param_id));
        compare_field("abort_code", 64'(want.abort_code), 64'(got.abort_code));
    endfunction
endclass

module sdo_round_robin_read_poller_unit_test;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 155;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  kind = KIND_TICK;
    logic [31:0]           now_us = '0;
    logic                  frame_standard = 1'b0;
    logic [10:0]           frame_id = '0;
    logic [3:0]            frame_length = '0;
    logic [63:0]           frame_payload = '0;
    logic                  transmit_accepted = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    logic                  request_valid;
    logic [63:0]           request_payload;
    logic                  abort_valid;
    logic [15:0]           abort_param_id;
    logic [31:0]           abort_code;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    poll_tracker sb;

    // stimulus knobs
    logic [31:0] clock_us = '0;
    int unsigned step_max = 40;
    int unsigned gap_odds = 4;      // one input gap per this many transfers, zero for none
    bit          stall_on = 1'b1;
    int          stall_left = 0;
    int unsigned cycle_count = 0;

    sdo_round_robin_read_poller_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .now_us            (now_us),
        .frame_standard    (frame_standard),
        .frame_id          (frame_id),
        .frame_length      (frame_length),
        .frame_payload     (frame_payload),
        .transmit_accepted (transmit_accepted),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .request_valid     (request_valid),
        .request_payload   (request_payload),
        .abort_valid       (abort_valid),
        .abort_param_id    (abort_param_id),
        .abort_code        (abort_code),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver drops out_ready in bursts of random length while stall_on is set
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (stall_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Reply monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_reply({request_valid, request_payload, abort_valid, abort_param_id,
                            abort_code});
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [63:0] sdo_frame(logic [7:0] cmd, logic [15:0] index,
                                              logic [7:0] sub, logic [31:0] code);
        return {code, sub, index[15:8], index[7:0], cmd};
    endfunction

    function automatic logic [15:0] sdo_read_index(logic [15:0] uid);
        return SDO_UID_INDEX | (uid >> 8);
    endfunction

    // Tick with junk in the frame fields, which a tick ignores
    function automatic item_t make_tick(logic [31:0] stamp, logic txok);
        item_t it;
        it.kind = KIND_TICK;
        it.now_us = stamp;
        it.frame_standard = 1'($urandom);
        it.frame_id = 11'($urandom);
        it.frame_length = 4'($urandom);
        it.frame_payload = {$urandom, $urandom};
        it.transmit_accepted = txok;
        return it;
    endfunction

    function automatic item_t make_frame(logic std, logic [10:0] id, logic [3:0] len,
                                         logic [63:0] data, logic [31:0] stamp);
        item_t it;
        it.kind = KIND_FRAME;
        it.now_us = stamp;
        it.frame_standard = std;
        it.frame_id = id;
        it.frame_length = len;
        it.frame_payload = data;
        it.transmit_accepted = 1'($urandom);
        return it;
    endfunction

    // Time stamps mostly creep forward; ticks often land right on the poll boundary
    function automatic logic [31:0] next_stamp(bit on_tick);
        int unsigned pick;
        pick = $urandom_range(0, 39);
        if (pick == 0)
            clock_us = $urandom;
        else if (on_tick && pick <= 6)
            clock_us = sb.poll_stamp + sb.poll_interval();
        else if (on_tick && pick <= 8)
            clock_us = sb.poll_stamp + sb.poll_interval() - 32'd1;
        else
            clock_us = clock_us + $urandom_range(0, step_max);
        return clock_us;
    endfunction

    // Mostly ticks, state frames and replies to the open request; some noise
    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        logic [7:0]  cmd;
        logic [15:0] index;
        logic [7:0]  sub;
        logic [1:0]  slot;
        logic [3:0]  len;
        logic [63:0] data;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return make_tick(next_stamp(1'b1), $urandom_range(0, 4) != 0);
        if (pick < 60)
        begin
            len = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(3, 8));
            data = {$urandom, $urandom};
            if ($urandom_range(0, 2) == 0)
                data[23:16] = '0;
            return make_frame($urandom_range(0, 9) != 0, sb.state_id, len, data,
                              next_stamp(1'b0));
        end
        if (pick < 90)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                len = 4'($urandom_range(0, 7));
            else if (pick <= 2)
                len = 4'($urandom_range(9, 15));
            else
                len = 4'd8;
            cmd = 8'($urandom);
            if (sb.busy && $urandom_range(0, 9) < 8)
            begin
                // answer the open request; aborts are saved for the closing part
                index = sb.busy_index;
                sub = sb.busy_sub;
                if (cmd == SDO_CMD_ABORT)
                    cmd = SDO_CMD_READ;
            end
            else
            begin
                slot = 2'($urandom_range(0, 2));
                index = sdo_read_index(sb.target_ids[slot]);
                sub = sb.target_ids[slot][7:0];
                if ($urandom_range(0, 1) == 0)
                    cmd = SDO_CMD_ABORT;
                // near miss only, so nothing gets retired here
                if (sb.busy && index == sb.busy_index && sub == sb.busy_sub)
                    sub = sub ^ (8'd1 << $urandom_range(0, 7));
            end
            return make_frame($urandom_range(0, 11) != 0, sb.resp_id, len,
                              sdo_frame(cmd, index, sub, $urandom), next_stamp(1'b0));
        end
        it = make_frame(1'($urandom), 11'($urandom), 4'($urandom), {$urandom, $urandom},
                        $urandom);
        it.kind = 1'($urandom);
        return it;
    endfunction

    // One input transfer, with an occasional idle burst ahead of it
    task automatic push_item(input item_t it);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        kind              <= it.kind;
        now_us            <= it.now_us;
        frame_standard    <= it.frame_standard;
        frame_id          <= it.frame_id;
        frame_length      <= it.frame_length;
        frame_payload     <= it.frame_payload;
        transmit_accepted <= it.transmit_accepted;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_transfer(it);
    endtask

    // Hold off input until every queued reply is back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.replies_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.load_reg(idx, data);
    endtask

    // Reprogram every register while idle; sel picks the flavor of setting
    task automatic program_settings(input int sel);
        logic [10:0] st_id;
        logic [10:0] rs_id;
        logic [31:0] act;
        logic [31:0] idl;
        logic [31:0] stale;
        logic [15:0] t0;
        logic [15:0] t1;
        logic [15:0] t2;
        drain();
        st_id = 11'($urandom);
        rs_id = 11'($urandom);
        act = $urandom_range(8, 64);
        idl = $urandom_range(64, 256);
        stale = $urandom_range(32, 400);
        t0 = 16'($urandom);
        t1 = 16'($urandom);
        t2 = 16'($urandom);
        step_max = 40;
        case (sel)
            1:
            begin
                st_id = '0;
                rs_id = '1;
                act = '0;
                idl = '0;
                stale = '0;
                t0 = '0;
                t1 = '1;
                step_max = 3;
            end
            2:
            begin
                st_id = '1;
                rs_id = '0;
                act = '1;
                idl = '1;
                stale = '1;
                t2 = '1;
                step_max = 1000;
            end
            3: rs_id = st_id;
            4: clock_us = 32'hFFFF_FFFF - 32'($urandom_range(0, 2000));
            default: ;
        endcase
        if (sel != 3 && rs_id == st_id)
            rs_id = ~st_id;
        // upper data bits past a register's width are junk
        write_reg(REG_STATE_FRAME_ID, {21'($urandom), st_id});
        write_reg(REG_RESPONSE_FRAME_ID, {21'($urandom), rs_id});
        write_reg(REG_ACTIVE_PERIOD, act);
        write_reg(REG_IDLE_PERIOD, idl);
        write_reg(REG_STALE_TIME, stale);
        write_reg(REG_TARGET_FIRST, {16'($urandom), t0});
        write_reg(REG_TARGET_SECOND, {16'($urandom), t1});
        write_reg(REG_TARGET_THIRD, {16'($urandom), t2});
        write_reg(REG_TARGET_THIRD + 4'($urandom_range(1, 8)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Directed cases on the reset configuration
    task automatic run_directed();
        item_t it;
        push_item(make_tick(32'd0, 1'b1));
        // extended frame on the state id: ignored
        push_item(make_frame(1'b0, RST_STATE_FRAME_ID, 4'd8, '1, 32'd1));
        // state frame too short
        push_item(make_frame(1'b1, RST_STATE_FRAME_ID, 4'd2, 64'h0077_0000, 32'd5));
        push_item(make_frame(1'b1, RST_STATE_FRAME_ID, 4'd3, 64'h005A_0000, 32'd10));
        // active period elapsed: slot zero goes out and stays open
        push_item(make_tick(32'd100000, 1'b1));
        // short reply ignored, over-long reply closes
        push_item(make_frame(1'b1, RST_RESPONSE_FRAME_ID, 4'd7,
                             sdo_frame(SDO_CMD_READ, sb.busy_index, sb.busy_sub, '1),
                             32'd100001));
        push_item(make_frame(1'b1, RST_RESPONSE_FRAME_ID, 4'd15,
                             sdo_frame(SDO_CMD_READ, sb.busy_index, sb.busy_sub, '1),
                             32'd100002));
        // refused transmit still rotates
        push_item(make_tick(32'd200000, 1'b0));
        // abort with nothing open
        push_item(make_frame(1'b1, RST_RESPONSE_FRAME_ID, 4'd8,
                             sdo_frame(SDO_CMD_ABORT, sdo_read_index(RST_TARGET_SECOND),
                                       RST_TARGET_SECOND[7:0], '1), 32'd200001));
        push_item(make_tick(32'd300000, 1'b1));
        // wrong sub, then wrong index
        push_item(make_frame(1'b1, RST_RESPONSE_FRAME_ID, 4'd8,
                             sdo_frame(SDO_CMD_ABORT, sb.busy_index, ~sb.busy_sub, '1),
                             32'd300001));
        push_item(make_frame(1'b1, RST_RESPONSE_FRAME_ID, 4'd8,
                             sdo_frame(SDO_CMD_ABORT, sb.busy_index ^ 16'h0100, sb.busy_sub,
                                       '1), 32'd300002));
        push_item(make_frame(1'b1, RST_RESPONSE_FRAME_ID, 4'd8,
                             sdo_frame(SDO_CMD_READ, sb.busy_index, sb.busy_sub, '0),
                             32'd300003));
        // mode goes stale, idle period not yet up
        push_item(make_tick(32'd900001, 1'b1));
        it = make_tick(32'hFFFF_FFFF, 1'b1);
        it.frame_standard = 1'b1;
        it.frame_id = '1;
        it.frame_length = '1;
        it.frame_payload = '1;
        push_item(it);
        // interval measured across the counter wrap; drops the open request
        push_item(make_tick(32'd1000000, 1'b1));
        push_item(make_frame(1'b1, RST_STATE_FRAME_ID, 4'd8, '1, 32'hFFFF_FFFF));
        push_item(make_frame(1'b1, 11'd0, 4'd0, '0, 32'd0));
        push_item(make_frame(1'b1, 11'h7FF, 4'd8, '1, 32'd2));
        push_item(make_tick(32'd1100000, 1'b1));
    endtask

    initial
    begin
        int p;
        int n;
        int guard;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();

        // random phases, each under a fresh setting
        for (p = 0; p < PHASES; p++)
        begin
            program_settings(p % 5);
            gap_odds = (p % 3 == 2) ? 0 : 2 + p;
            stall_on = (p % 4 != 3);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                push_item(random_item());
                if ($urandom_range(0, 199) == 0)
                    drain();
            end
        end

        // closing part, no idling: abort every target, then poll with all retired
        gap_odds = 0;
        stall_on = 1'b0;
        program_settings(0);
        guard = 0;
        while (sb.retired != 3'b111 && guard < 400)
        begin
            if (sb.busy)
                push_item(make_frame(1'b1, sb.resp_id, 4'd8,
                                     sdo_frame(SDO_CMD_ABORT, sb.busy_index, sb.busy_sub,
                                               $urandom), next_stamp(1'b0)));
            else
                push_item(make_tick(sb.poll_stamp + sb.poll_interval(), 1'b1));
            guard++;
        end
        for (n = 0; n < 6; n++)
            push_item(make_tick(sb.poll_stamp + sb.poll_interval(), 1'b1));
        for (n = 0; n < 10; n++)
            push_item(random_item());
        drain();

        if (sb.failures == 0 && sb.replies_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
